@@ rtl/lcnc_pkg.sv @@
// shared types, constants and helper functions of the luhn card number check
// no dependencies; imported by every module of the block
`default_nettype none

package lcnc_pkg;

  localparam int unsigned CardW       = 64;
  localparam int unsigned DigitW      = 4;
  localparam int unsigned MaxDigits   = 20;
  localparam int unsigned BcdW        = MaxDigits * DigitW;
  localparam int unsigned BitsPerStep = 4;
  localparam int unsigned ConvSteps   = CardW / BitsPerStep;
  localparam int unsigned CountW      = 5;
  localparam int unsigned VerdictW    = 2;

  localparam logic [VerdictW-1:0] VerdictInvalid = 2'd0;
  localparam logic [VerdictW-1:0] VerdictBrand15 = 2'd1;
  localparam logic [VerdictW-1:0] VerdictBrand16 = 2'd2;
  localparam logic [VerdictW-1:0] VerdictBrand4  = 2'd3;

  localparam logic [CountW-1:0] Len13 = 5'd13;
  localparam logic [CountW-1:0] Len15 = 5'd15;
  localparam logic [CountW-1:0] Len16 = 5'd16;
  localparam logic [CountW-1:0] LenMax = 5'd20;

  localparam logic [DigitW-1:0] Digit1 = 4'd1;
  localparam logic [DigitW-1:0] Digit3 = 4'd3;
  localparam logic [DigitW-1:0] Digit4 = 4'd4;
  localparam logic [DigitW-1:0] Digit5 = 4'd5;
  localparam logic [DigitW-1:0] Digit7 = 4'd7;
  localparam logic [DigitW-1:0] Ten    = 4'd10;

  typedef enum logic [1:0] {
    StIdle,
    StConv,
    StScan,
    StHold
  } lcnc_state_e;

  typedef struct packed {
    logic load;
    logic convert;
    logic shift;
  } lcnc_ctrl_t;

  typedef struct packed {
    logic [DigitW-1:0] sum_mod10;
    logic [CountW-1:0] count;
    logic [DigitW-1:0] lead;
    logic [DigitW-1:0] second;
  } lcnc_scan_t;

  // digit sum of twice a decimal digit
  function automatic logic [DigitW-1:0] doubled_digit_sum(input logic [DigitW-1:0] d);
    logic [DigitW-1:0] r;
    case (d)
      4'd0:    r = 4'd0;
      4'd1:    r = 4'd2;
      4'd2:    r = 4'd4;
      4'd3:    r = 4'd6;
      4'd4:    r = 4'd8;
      4'd5:    r = 4'd1;
      4'd6:    r = 4'd3;
      4'd7:    r = 4'd5;
      4'd8:    r = 4'd7;
      4'd9:    r = 4'd9;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/lcnc_bcd_conv.sv @@
// binary to bcd converter, shift-and-add-3, a few input bits per cycle,
// then shifts the digits out least significant first; uses lcnc_pkg
`default_nettype none

module lcnc_bcd_conv
  import lcnc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire lcnc_ctrl_t        ctrl_i,
  input  wire logic [CardW-1:0]  card_number_i,
  output logic      [DigitW-1:0] digit_o
);

  logic [CardW-1:0] bin_q, bin_d;
  logic [BcdW-1:0]  bcd_q, bcd_d;

  always_comb begin
    bin_d = bin_q;
    bcd_d = bcd_q;
    if (ctrl_i.load) begin
      bin_d = card_number_i;
      bcd_d = '0;
    end else if (ctrl_i.convert) begin
      for (int s = 0; s < BitsPerStep; s++) begin
        for (int k = 0; k < MaxDigits; k++) begin
          if (bcd_d[k*DigitW +: DigitW] >= Digit5) begin
            bcd_d[k*DigitW +: DigitW] = bcd_d[k*DigitW +: DigitW] + Digit3;
          end
        end
        bcd_d = {bcd_d[BcdW-2:0], bin_d[CardW-1]};
        bin_d = {bin_d[CardW-2:0], 1'b0};
      end
    end else if (ctrl_i.shift) begin
      bcd_d = {{DigitW{1'b0}}, bcd_d[BcdW-1:DigitW]};
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign digit_o = bcd_q[DigitW-1:0];

endmodule

`default_nettype wire

@@ rtl/lcnc_digit_scan.sv @@
// serial digit scanner: luhn sum mod 10, digit count and the two leading
// digits, one per cycle during shift, least significant first; uses lcnc_pkg
`default_nettype none

module lcnc_digit_scan
  import lcnc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire lcnc_ctrl_t        ctrl_i,
  input  wire logic [DigitW-1:0] digit_i,
  output lcnc_scan_t             scan_o
);

  logic [DigitW-1:0] sum_q, sum_d;
  logic [CountW-1:0] count_q, count_d;
  logic [CountW-1:0] pos_q, pos_d;
  logic [DigitW-1:0] lead_q, lead_d;
  logic [DigitW-1:0] second_q, second_d;
  logic [DigitW-1:0] prev_q, prev_d;
  logic [DigitW-1:0] addend;
  logic [DigitW:0]   raw_sum;

  always_comb begin
    // odd positions from the right, rightmost being zero, are doubled
    addend  = pos_q[0] ? doubled_digit_sum(digit_i) : digit_i;
    raw_sum = {1'b0, sum_q} + {1'b0, addend};
    sum_d    = sum_q;
    count_d  = count_q;
    pos_d    = pos_q;
    lead_d   = lead_q;
    second_d = second_q;
    prev_d   = prev_q;
    if (ctrl_i.load) begin
      sum_d    = '0;
      count_d  = '0;
      pos_d    = '0;
      lead_d   = '0;
      second_d = '0;
      prev_d   = '0;
    end else if (ctrl_i.shift) begin
      if (raw_sum >= {1'b0, Ten}) begin
        sum_d = DigitW'(raw_sum - {1'b0, Ten});
      end else begin
        sum_d = raw_sum[DigitW-1:0];
      end
      // highest nonzero digit so far fixes length and leading pair
      if (digit_i != '0) begin
        count_d  = pos_q + 1'b1;
        lead_d   = digit_i;
        second_d = prev_q;
      end
      prev_d = digit_i;
      pos_d  = pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q    <= sum_d;
    count_q  <= count_d;
    pos_q    <= pos_d;
    lead_q   <= lead_d;
    second_q <= second_d;
    prev_q   <= prev_d;
  end

  assign scan_o.sum_mod10 = sum_q;
  assign scan_o.count     = count_q;
  assign scan_o.lead      = lead_q;
  assign scan_o.second    = second_q;

endmodule

`default_nettype wire

@@ rtl/luhn_card_number_check_core.sv @@
// Luhn card number check, top level: sequencer, brand classification and
// result register; uses lcnc_pkg, lcnc_bcd_conv and lcnc_digit_scan
`default_nettype none

// One card number item is taken while card_number_ready_o is high. It is
// converted to 20 decimal digits by a shift-and-add-3 converter at four input
// bits per cycle, then the digits are shifted out one per cycle into the Luhn
// accumulator, which also finds the digit count and the two leading digits.
// The hold state then classifies and loads the result register, stalling
// while a previous result still waits; a new item is taken only once this
// load is done. The result register lets the next item be taken while the
// previous result still waits for result_ready_i.
module luhn_card_number_check_core
  import lcnc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                card_number_valid_i,
  output logic                     card_number_ready_o,
  input  wire logic [CardW-1:0]    card_number_i,
  output logic                     result_valid_o,
  input  wire logic                result_ready_i,
  output logic      [VerdictW-1:0] verdict_o,
  output logic                     luhn_ok_o,
  output logic      [CountW-1:0]   digit_count_o
);

  lcnc_state_e       state_q, state_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic              out_load;
  lcnc_ctrl_t        ctrl;
  logic [DigitW-1:0] digit;
  lcnc_scan_t        scan;

  logic [VerdictW-1:0] verdict_q, verdict_d;
  logic                luhn_ok_q, luhn_ok_d;
  logic [CountW-1:0]   count_q;

  lcnc_bcd_conv u_bcd_conv (
    .clk_i         (clk_i),
    .ctrl_i        (ctrl),
    .card_number_i (card_number_i),
    .digit_o       (digit)
  );

  lcnc_digit_scan u_digit_scan (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .digit_i (digit),
    .scan_o  (scan)
  );

  always_comb begin
    state_d             = state_q;
    cnt_d               = cnt_q;
    ctrl                = '0;
    out_load            = 1'b0;
    card_number_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        card_number_ready_o = 1'b1;
        if (card_number_valid_i) begin
          ctrl.load = 1'b1;
          cnt_d     = '0;
          state_d   = StConv;
        end
      end
      StConv: begin
        ctrl.convert = 1'b1;
        cnt_d        = cnt_q + 1'b1;
        if (cnt_q == CountW'(ConvSteps - 1)) begin
          cnt_d   = '0;
          state_d = StScan;
        end
      end
      StScan: begin
        ctrl.shift = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == CountW'(MaxDigits - 1)) begin
          cnt_d   = '0;
          state_d = StHold;
        end
      end
      StHold: begin
        if (!out_valid_q || result_ready_i) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // brand classification, only when the luhn sum passes
  always_comb begin
    luhn_ok_d = (scan.sum_mod10 == '0);
    verdict_d = VerdictInvalid;
    if (luhn_ok_d) begin
      if (scan.count == Len15 && scan.lead == Digit3 &&
          (scan.second == Digit4 || scan.second == Digit7)) begin
        verdict_d = VerdictBrand15;
      end else if (scan.count == Len16 && scan.lead == Digit5 &&
                   scan.second >= Digit1 && scan.second <= Digit5) begin
        verdict_d = VerdictBrand16;
      end else if ((scan.count == Len13 || scan.count == Len16) &&
                   scan.lead == Digit4) begin
        verdict_d = VerdictBrand4;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (result_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      verdict_q <= verdict_d;
      luhn_ok_q <= luhn_ok_d;
      count_q   <= scan.count;
    end
  end

  assign result_valid_o = out_valid_q;
  assign verdict_o      = verdict_q;
  assign luhn_ok_o      = luhn_ok_q;
  assign digit_count_o  = count_q;

endmodule

`default_nettype wire

@@ rtl/lcnc_checker.sv @@
// port-level checker of the luhn card number check and its bind to the top
// level; uses lcnc_pkg
`default_nettype none

module lcnc_checker
  import lcnc_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                card_number_valid_i,
  input wire logic                card_number_ready_o,
  input wire logic                result_valid_o,
  input wire logic                result_ready_i,
  input wire logic [VerdictW-1:0] verdict_o,
  input wire logic                luhn_ok_o,
  input wire logic [CountW-1:0]   digit_count_o
);

  // a waiting result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_ready_i |=>
      result_valid_o && $stable(verdict_o) && $stable(luhn_ok_o) &&
      $stable(digit_count_o))
    else $error("stalled result changed");

  // one item at a time: busy right after an item is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    card_number_valid_i && card_number_ready_o |=> !card_number_ready_o)
    else $error("item taken while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> digit_count_o <= LenMax)
    else $error("digit count out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && verdict_o != VerdictInvalid |-> luhn_ok_o)
    else $error("brand given without luhn pass");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |->
      (verdict_o != VerdictBrand15 || digit_count_o == Len15) &&
      (verdict_o != VerdictBrand16 || digit_count_o == Len16) &&
      (verdict_o != VerdictBrand4 || digit_count_o == Len13 || digit_count_o == Len16))
    else $error("brand does not match digit count");

endmodule

bind luhn_card_number_check_core lcnc_checker u_lcnc_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .card_number_valid_i (card_number_valid_i),
  .card_number_ready_o (card_number_ready_o),
  .result_valid_o      (result_valid_o),
  .result_ready_i      (result_ready_i),
  .verdict_o           (verdict_o),
  .luhn_ok_o           (luhn_ok_o),
  .digit_count_o       (digit_count_o)
);

`default_nettype wire
